@@ design/assert_macros.svh @@
// assertion helpers used by ogpu_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define OGPU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define OGPU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// consequent holds after the antecedent, at the delay given by n
`define OGPU_ASSERT_AFTER(label, clk, rst, ante, n, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error(msg);

`endif

@@ design/ogpu_pkg.sv @@
package ogpu_pkg;

   // grid geometry default
   localparam int GRID_SIDE_DEFAULT = 256;

   // register file
   localparam int CSR_AW = 2;
   localparam int CSR_DW = 16;
   localparam logic [CSR_AW-1:0] CSR_CELLS_PER_METRE = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_HEIGHT_MIN      = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_HEIGHT_MAX      = 2'd2;
   localparam logic [CSR_AW-1:0] CSR_HIT_THRESHOLD   = 2'd3;

   localparam logic [15:0]        CELLS_PER_METRE_RST = 16'd2560;
   localparam logic signed [15:0] HEIGHT_MIN_RST      = 16'sd0;
   localparam logic signed [15:0] HEIGHT_MAX_RST      = 16'sd512;
   localparam logic [6:0]         HIT_THRESHOLD_RST   = 7'd50;

   // cell values
   localparam logic signed [7:0] CELL_UNKNOWN   = -8'sd1;
   localparam logic signed [7:0] CELL_FIRST_HIT = 8'sd10;
   localparam logic signed [7:0] CELL_STEP      = 8'sd10;
   localparam logic signed [7:0] CELL_OCCUPIED  = 8'sd100;

   // request actions
   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_READ   = 1'b1;

   typedef struct packed {
      logic               action;
      logic signed [15:0] x_pos;
      logic signed [15:0] y_pos;
      logic signed [15:0] z_pos;
      logic [15:0]        read_index;
   } req_item_type;

   typedef struct packed {
      logic              in_grid;
      logic [15:0]       cell_index;
      logic signed [7:0] cell_value;
   } rsp_item_type;

endpackage

@@ design/ogpu_axis_map.sv @@
module ogpu_axis_map #(
   parameter int GRID_SIDE = ogpu_pkg::GRID_SIDE_DEFAULT,
   parameter int CW        = $clog2(GRID_SIDE)
) (
   input  logic signed [32:0] prod,
   output logic               in_range,
   output logic [CW-1:0]      coord
);

   localparam int HALF = GRID_SIDE / 2;
   localparam logic signed [32:0] LIMIT = 33'(HALF * 65536);
   localparam logic [CW:0] HALF_C = HALF[CW:0];

   logic [32:0] mag;
   logic [CW:0] cmag;
   logic [CW:0] sum;

   // strict bounds check on the Q16.16 product
   assign in_range = (prod < LIMIT) && (prod > -LIMIT);

   // truncate toward zero, then offset by half the side
   always_comb begin
      mag  = prod[32] ? 33'(-prod) : 33'(prod);
      cmag = {1'b0, mag[CW+15:16]};
      if (prod[32]) begin
         sum = HALF_C - cmag;
      end else begin
         sum = HALF_C + cmag;
      end
      coord = sum[CW-1:0];
   end

endmodule

@@ design/ogpu_cell_store.sv @@
module ogpu_cell_store #(
   parameter int DEPTH = ogpu_pkg::GRID_SIDE_DEFAULT * ogpu_pkg::GRID_SIDE_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output logic signed [7:0]   rd_data,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  logic signed [7:0]   wr_data,
   output logic                ready
);

   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   logic signed [7:0] mem [DEPTH];
   logic signed [7:0] rd_data_ff;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic              clearing_ff, clearing_in;

   // clearing pass sequencer
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_ADDR) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clearing_ff <= clearing_in;
      end
   end

   // single write port, shared by clearing pass and updates
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_addr_ff] <= ogpu_pkg::CELL_UNKNOWN;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign ready   = ~clearing_ff;

endmodule

@@ design/occupancy_grid_point_update_core.sv @@
// Occupancy grid point update core.
// Keeps a GRID_SIDE x GRID_SIDE grid of signed byte cells in one on-chip RAM.
// Request channel: start/busy; a transaction is taken at a clock edge with
// start high and busy low. action selects insert point or read cell.
// Response channel: rsp_valid strobes one cycle per transaction with
// rsp_item; the receiver cannot stall, so every result is dropped onto the
// ports for exactly that cycle.
// The accepting edge loads the capture registers and enters the scale state,
// which forms the cell address and issues the registered read; the update
// state writes back and loads the response register, which raises the strobe.
// busy covers the whole read-modify-write loop, so two accesses never overlap.
// Reset: synchronous, active high. After reset a clearing pass writes
// "unknown" to every cell, one cell a cycle, GRID_SIDE*GRID_SIDE cells
// (65536 at the default side); busy stays high during it. Register writes
// on the csr port are taken at any time, including during the pass.
module occupancy_grid_point_update_core #(
   parameter int GRID_SIDE = ogpu_pkg::GRID_SIDE_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  ogpu_pkg::req_item_type           req_item,
   output logic                             rsp_valid,
   output ogpu_pkg::rsp_item_type           rsp_item,
   input  logic                             csr_we,
   input  logic [ogpu_pkg::CSR_AW-1:0]      csr_addr,
   input  logic [ogpu_pkg::CSR_DW-1:0]      csr_wdata
);

   localparam int unsigned CELL_COUNT = GRID_SIDE * GRID_SIDE;
   localparam int AW = $clog2(CELL_COUNT);
   localparam int CW = $clog2(GRID_SIDE);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCALE  = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   // configuration registers
   logic [15:0]        cells_per_metre_ff;
   logic signed [15:0] height_min_ff;
   logic signed [15:0] height_max_ff;
   logic [6:0]         hit_threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_per_metre_ff <= ogpu_pkg::CELLS_PER_METRE_RST;
         height_min_ff      <= ogpu_pkg::HEIGHT_MIN_RST;
         height_max_ff      <= ogpu_pkg::HEIGHT_MAX_RST;
         hit_threshold_ff   <= ogpu_pkg::HIT_THRESHOLD_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            ogpu_pkg::CSR_CELLS_PER_METRE: cells_per_metre_ff <= csr_wdata;
            ogpu_pkg::CSR_HEIGHT_MIN:      height_min_ff      <= $signed(csr_wdata);
            ogpu_pkg::CSR_HEIGHT_MAX:      height_max_ff      <= $signed(csr_wdata);
            ogpu_pkg::CSR_HIT_THRESHOLD:   hit_threshold_ff   <= csr_wdata[6:0];
         endcase
      end
   end

   // control
   logic [1:0] state_ff, state_in;
   logic       store_ready;
   logic       accept;

   assign busy   = ~store_ready | (state_ff != ST_IDLE);
   assign accept = start & ~busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // capture stage: scale both axes by the resolution register
   logic signed [16:0] cpm_s;
   logic signed [32:0] prod_x_ff, prod_y_ff;
   logic signed [15:0] z_ff;
   logic               action_ff;
   logic [15:0]        read_index_ff;

   assign cpm_s = $signed({1'b0, cells_per_metre_ff});

   always_ff @(posedge clock) begin
      if (accept) begin
         prod_x_ff     <= 33'(req_item.x_pos * cpm_s);
         prod_y_ff     <= 33'(req_item.y_pos * cpm_s);
         z_ff          <= req_item.z_pos;
         action_ff     <= req_item.action;
         read_index_ff <= req_item.read_index;
      end
   end

   // scale stage: bounds check, cell address, issue the read
   logic          x_ok, y_ok;
   logic [CW-1:0] col, row;
   logic [AW-1:0] cell_addr;
   logic [AW-1:0] rd_addr;
   logic          read_ok;

   ogpu_axis_map #(.GRID_SIDE(GRID_SIDE), .CW(CW)) u_map_x (
      .prod     (prod_x_ff),
      .in_range (x_ok),
      .coord    (col)
   );

   ogpu_axis_map #(.GRID_SIDE(GRID_SIDE), .CW(CW)) u_map_y (
      .prod     (prod_y_ff),
      .in_range (y_ok),
      .coord    (row)
   );

   assign cell_addr = AW'(AW'(row) * AW'(GRID_SIDE)) + AW'(col);
   assign read_ok   = {16'b0, read_index_ff} < 32'(CELL_COUNT);
   assign rd_addr   = (action_ff == ogpu_pkg::ACTION_READ) ? AW'(read_index_ff) : cell_addr;

   logic [AW-1:0] addr_ff;
   logic          hit_ok_ff;
   logic          z_in_band_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_SCALE) begin
         addr_ff      <= cell_addr;
         hit_ok_ff    <= (action_ff == ogpu_pkg::ACTION_READ) ? read_ok : (x_ok & y_ok);
         z_in_band_ff <= (z_ff > height_min_ff) && (z_ff < height_max_ff);
      end
   end

   // cell store with clearing pass
   logic signed [7:0] rd_data;
   logic              wr_en;
   logic signed [7:0] new_value;

   ogpu_cell_store #(.DEPTH(CELL_COUNT), .AW(AW)) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (state_ff == ST_SCALE),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (new_value),
      .ready   (store_ready)
   );

   // update stage: hit counting on the value read back
   logic signed [8:0] cur;
   logic signed [8:0] thr;
   logic signed [8:0] upd;

   always_comb begin
      cur = 9'(rd_data);
      thr = $signed({2'b00, hit_threshold_ff});
      if (rd_data == ogpu_pkg::CELL_UNKNOWN) begin
         upd = 9'(ogpu_pkg::CELL_FIRST_HIT);
      end else begin
         upd = cur;
      end
      if (z_in_band_ff) begin
         if (upd < thr) begin
            upd = upd + 9'(ogpu_pkg::CELL_STEP);
         end
         if (upd >= thr) begin
            upd = 9'(ogpu_pkg::CELL_OCCUPIED);
         end
      end
      new_value = upd[7:0];
   end

   assign wr_en = (state_ff == ST_UPDATE) && (action_ff == ogpu_pkg::ACTION_INSERT) && hit_ok_ff;

   // response register
   logic                   rsp_valid_ff;
   ogpu_pkg::rsp_item_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_UPDATE);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_UPDATE) begin
         rsp_ff.in_grid <= hit_ok_ff;
         if (action_ff == ogpu_pkg::ACTION_READ) begin
            rsp_ff.cell_index <= read_index_ff;
            rsp_ff.cell_value <= hit_ok_ff ? rd_data : 8'sd0;
         end else begin
            rsp_ff.cell_index <= hit_ok_ff ? 16'(addr_ff) : 16'd0;
            rsp_ff.cell_value <= hit_ok_ff ? new_value : 8'sd0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

@@ design/ogpu_checker.sv @@
`include "assert_macros.svh"

module ogpu_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input ogpu_pkg::rsp_item_type rsp_item
);

   logic accept;

   assign accept = start & ~busy;

   // an accepted transaction holds the request side off while it runs
   `OGPU_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "busy not raised after accept")

   // each accepted transaction is followed by its response strobe
   `OGPU_ASSERT_AFTER(a_rsp_latency, clock, reset, accept, 3, rsp_valid, "response strobe missing")

   // response strobes never run back to back
   `OGPU_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "response strobe too long")

   // the block is ready for the next transaction while a response shows
   `OGPU_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid, !busy, "busy during response")

   // a miss reports a zero cell value
   `OGPU_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid && !rsp_item.in_grid, rsp_item.cell_value == 8'sd0, "nonzero value on miss")

endmodule

bind occupancy_grid_point_update_core ogpu_checker u_ogpu_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
